// ----- rtl/srpi_pkg.sv -----
// Shared types and constants for the stepper ramp pulse interval block.
// No dependencies; every other file of the block depends on this package.
package srpi_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned TimerW = 16;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned CfgW   = 32;

  // lowest interval ever issued, and the cruise interval after reset
  localparam logic [TimerW-1:0] MinInterval  = 16'd35;
  localparam logic [TimerW-1:0] CruiseResetV = 16'd50;

  typedef enum logic [1:0] {
    OpStep      = 2'd0,
    OpLoadAccel = 2'd1,
    OpLoadDecel = 2'd2,
    OpStart     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PhaseAccel  = 2'd0,
    PhaseCruise = 2'd1,
    PhaseDecel  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CfgAccelEnd   = 2'd0,
    CfgDecelStart = 2'd1,
    CfgCruise     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e               op;
    logic [PosW-1:0]   position;
    logic [TimerW-1:0] timer_now;
    logic [IdxW-1:0]   entry_index;
    logic [15:0]       entry_interval;
    logic [15:0]       entry_length;
  } in_item_t;

  typedef struct packed {
    logic [TimerW-1:0] compare_value;
    logic [15:0]       interval;
    phase_e            phase;
  } out_item_t;

endpackage

// ----- rtl/srpi_in_if.sv -----
// Input channel of the ramp block: valid/ready handshake with an in_item_t payload.
// Depends on srpi_pkg.
interface srpi_in_if;
  logic              valid;
  logic              ready;
  srpi_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/srpi_out_if.sv -----
// Result channel of the ramp block: valid/ready handshake with an out_item_t payload.
// Depends on srpi_pkg.
interface srpi_out_if;
  logic               valid;
  logic               ready;
  srpi_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/stepper_ramp_pulse_interval.sv -----
// Stepper ramp pulse interval generator: top level, segment tables and walk state.
// Depends on srpi_pkg, srpi_in_if and srpi_out_if.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------------------
//  in_i     | in  | valid/ready   | op, position, timer_now, entry_* (in_item_t)
//  out_o    | out | valid/ready   | compare_value, interval, phase (out_item_t)
//  cfg      | in  | cfg_we_i only | cfg_idx_i selects register, cfg_data_i value
//
// One item per cycle unless stalled: an accepted item sits in the input register,
// where a single pass (table read, 32-bit sum add and compare, table read) decides
// it; a step pulse's result is registered and shows on out_o in the next cycle.
// Reset sets up the walk state and config registers; the segment tables keep no
// reset value and must be loaded before a move reads them.
// When out_o stalls with a result waiting, a step pulse in the input register
// holds and in_i.ready drops; loads and start-moves still pass through.
module stepper_ramp_pulse_interval #(
  parameter int unsigned SEGMENTS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  srpi_in_if.sink                      in_i,
  srpi_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [srpi_pkg::CfgW-1:0]    cfg_data_i
);
  import srpi_pkg::*;

  localparam int unsigned SegW = $clog2(SEGMENTS);
  localparam logic [SegW-1:0] LastSeg = SegW'(SEGMENTS - 1);

  // configuration
  logic [PosW-1:0]   accel_end_q, decel_start_q;
  logic [TimerW-1:0] cruise_q;

  // segment tables, split so each array is read at one address
  logic [15:0] accel_ival_q [SEGMENTS];
  logic [15:0] accel_len_q  [SEGMENTS];
  logic [15:0] decel_ival_q [SEGMENTS];
  logic [15:0] decel_len_q  [SEGMENTS];

  // walk state
  logic [SegW-1:0] accel_seg_q, decel_seg_q;
  logic [PosW-1:0] accel_sum_q, decel_sum_q;
  logic            accel_pend_q, decel_pend_q;

  // input register and result register
  logic      s0_valid_q;
  in_item_t  s0_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;

  logic        in_fire, s0_fire, s0_step, s0_load_ok;
  logic [SegW-1:0] load_addr;

  // walk next values
  logic [PosW-1:0] a_sum_d, d_sum_d;
  logic [SegW-1:0] a_seg_d, d_seg_d;
  logic            a_adv, d_adv;
  logic [15:0]     a_ival, d_ival;

  phase_e      phase_d;
  logic [15:0] raw_ival, ival_d;
  out_item_t   out_item_d;

  assign in_fire = in_i.valid && in_i.ready;
  assign s0_step = s0_item_q.op == OpStep;
  // only a step pulse needs room in the result register
  assign s0_fire = s0_valid_q && (!s0_step || !out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || s0_fire;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // loads past the last segment are dropped
  assign s0_load_ok = 32'(s0_item_q.entry_index) < SEGMENTS;
  assign load_addr  = SegW'(s0_item_q.entry_index);

  // Ramp walk: fold in the current segment's length once, then step to the next
  // segment (saturating at the last) once the position passes the running sum.
  always_comb begin
    a_sum_d = accel_pend_q ? accel_sum_q + PosW'(accel_len_q[accel_seg_q]) : accel_sum_q;
    a_adv   = s0_item_q.position > a_sum_d;
    a_seg_d = (a_adv && accel_seg_q != LastSeg) ? accel_seg_q + SegW'(1) : accel_seg_q;
    a_ival  = accel_ival_q[a_seg_d];

    d_sum_d = decel_pend_q ? decel_sum_q + PosW'(decel_len_q[decel_seg_q]) : decel_sum_q;
    d_adv   = s0_item_q.position > d_sum_d;
    d_seg_d = (d_adv && decel_seg_q != LastSeg) ? decel_seg_q + SegW'(1) : decel_seg_q;
    d_ival  = decel_ival_q[d_seg_d];
  end

  // Phase pick: acceleration wins when the boundaries overlap.
  always_comb begin
    if (s0_item_q.position < accel_end_q) begin
      phase_d  = PhaseAccel;
      raw_ival = a_ival;
    end else if (s0_item_q.position < decel_start_q) begin
      phase_d  = PhaseCruise;
      raw_ival = cruise_q;
    end else begin
      phase_d  = PhaseDecel;
      raw_ival = d_ival;
    end
    ival_d = (raw_ival < MinInterval) ? MinInterval : raw_ival;
    out_item_d.interval      = ival_d;
    out_item_d.compare_value = s0_item_q.timer_now + ival_d;
    out_item_d.phase         = phase_d;
  end

  // control and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      accel_end_q   <= '0;
      decel_start_q <= '0;
      cruise_q      <= CruiseResetV;
      accel_seg_q   <= '0;
      accel_sum_q   <= '0;
      accel_pend_q  <= 1'b1;
      decel_seg_q   <= '0;
      decel_sum_q   <= '0;
      decel_pend_q  <= 1'b1;
    end else begin
      if (in_fire) begin
        s0_valid_q <= 1'b1;
      end else if (s0_fire) begin
        s0_valid_q <= 1'b0;
      end

      if (s0_fire && s0_step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgAccelEnd:   accel_end_q   <= cfg_data_i;
          CfgDecelStart: decel_start_q <= cfg_data_i;
          CfgCruise:     cruise_q      <= cfg_data_i[TimerW-1:0];
          default: ;
        endcase
      end

      if (s0_fire) begin
        case (s0_item_q.op)
          OpStart: begin
            accel_seg_q  <= '0;
            accel_sum_q  <= '0;
            accel_pend_q <= 1'b1;
            decel_seg_q  <= '0;
            decel_sum_q  <= decel_start_q;
            decel_pend_q <= 1'b1;
          end
          OpStep: begin
            if (phase_d == PhaseAccel) begin
              accel_seg_q  <= a_seg_d;
              accel_sum_q  <= a_sum_d;
              accel_pend_q <= a_adv;
            end else if (phase_d == PhaseDecel) begin
              decel_seg_q  <= d_seg_d;
              decel_sum_q  <= d_sum_d;
              decel_pend_q <= d_adv;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload: input item, result and tables carry no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_item_q <= in_i.data;
    end
    if (s0_fire && s0_step) begin
      out_item_q <= out_item_d;
    end
    if (s0_fire && s0_load_ok && s0_item_q.op == OpLoadAccel) begin
      accel_ival_q[load_addr] <= s0_item_q.entry_interval;
      accel_len_q[load_addr]  <= s0_item_q.entry_length;
    end
    if (s0_fire && s0_load_ok && s0_item_q.op == OpLoadDecel) begin
      decel_ival_q[load_addr] <= s0_item_q.entry_interval;
      decel_len_q[load_addr]  <= s0_item_q.entry_length;
    end
  end

  // segment indices never run past the table
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accel_seg_q <= LastSeg && decel_seg_q <= LastSeg)
    else $error("segment index beyond last segment");

  // a start-move rearms both walks
  a_start_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && s0_item_q.op == OpStart) |=>
      (accel_pend_q && decel_pend_q && accel_sum_q == '0 && accel_seg_q == '0 &&
       decel_seg_q == '0))
    else $error("start move did not rearm the walk");

  // issued interval respects the clamp
  a_min_ival: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_item_q.interval >= MinInterval)
    else $error("interval below minimum");

  // input side only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s0_valid_q && s0_step && out_valid_q && !out_o.ready))
    else $error("input stalled without a waiting result");

  // non-step items never produce a result
  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_fire && !s0_step && (out_o.ready || !out_valid_q)) |=> !out_valid_q)
    else $error("result produced by a non-step item");

endmodule
